// ===== rtl/core/hng_pkg.sv =====
package hng_pkg;

   // Map geometry
   localparam int MaxSize  = 1024;
   localparam int ColW     = $clog2(MaxSize);
   localparam int SizeW    = ColW + 1;
   localparam int MemAw    = ColW + 1;
   localparam int HeightW  = 16;
   localparam int DiffW    = HeightW + 1;

   // Normal arithmetic
   localparam int SqW      = 32;
   localparam int LenW     = SqW + 2;
   localparam int AccW     = 72;
   localparam int LoW      = 15;
   localparam int BitW     = 4;
   localparam int LastBit  = LoW - 1;
   localparam int RhsShift = 30;
   localparam int YConst   = 512;
   localparam int YSquare  = YConst * YConst;
   localparam int NumComp  = 3;
   localparam int NumSlots = 6;

   // Configuration registers
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic CsrMapSizeIdx = 1'b0;
   localparam logic [SizeW-1:0] MapSizeReset = SizeW'(MaxSize);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_WRITE, S_VERT, S_SQ, S_SETUP, S_ITER, S_PACK, S_OUT
   } state_type;

   // Row store reads: up = previous row bank, dn = current row bank
   typedef enum logic [2:0] {
      RD_UP_C, RD_UP_L, RD_UP_R, RD_DN_C, RD_DN_L, RD_DN_LL
   } rd_sel_type;

   // Which vertex a sample releases
   typedef enum logic [1:0] {
      V_ABOVE, V_LEFT, V_CORNER
   } vert_type;

   typedef struct packed {
      logic              load_in;
      logic              rd_en;
      rd_sel_type        rd_sel;
      logic              wr_en;
      logic              vload;
      vert_type          vsel;
      logic              sq_en;
      logic              setup;
      logic              iter;
      logic [BitW-1:0]   bitpos;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic first_row;
      logic has_left;
      logic has_corner;
      logic rsp_fire;
   } status_type;

endpackage

// ===== rtl/core/hng_channels.sv =====
interface hng_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] height;
   modport source (output valid, output height, input ready);
   modport sink   (input valid, input height, output ready);
endinterface

interface hng_rsp_if;
   logic               valid;
   logic               ready;
   logic [9:0]         column;
   logic [9:0]         row;
   logic signed [15:0] vertex_height;
   logic signed [15:0] normal_x;
   logic [14:0]        normal_y;
   logic signed [15:0] normal_z;
   logic               last_of_run;
   logic               map_done;
   modport source (output valid, output column, output row, output vertex_height,
                   output normal_x, output normal_y, output normal_z,
                   output last_of_run, output map_done, input ready);
   modport sink   (input valid, input column, input row, input vertex_height,
                   input normal_x, input normal_y, input normal_z,
                   input last_of_run, input map_done, output ready);
endinterface

// ===== rtl/core/heightmap_normal_generator_core.sv =====
// Height map to vertex normals. Height samples (signed Q8.8) stream in row by
// row, column fastest, over a square map of map_size x map_size points
// (register 0 at byte address 0, clamped to 2..1024; any write restarts the
// map). Each vertex word carries column, row, height and a unit normal in
// Q1.14 built from central differences (left - right, 2.0, down - up), with
// neighbors outside the map taken as zero height. A vertex leaves once the
// sample below it arrives; samples of the last row also release the row's
// vertices, so one sample gives zero to three words, last_of_run marks the
// final word of a sample and map_done the final vertex of the map. The block
// works on one sample at a time: it accepts the sample, makes six reads of the
// two-bank row store and writes back, then for each released word runs the
// 15-step bit-serial normalizer and holds the word until it is taken. The row
// store needs no clearing after reset.
module heightmap_normal_generator_core (
   input  logic        clock,
   input  logic        reset,
   hng_req_if.sink     req_ch,
   hng_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import hng_pkg::*;

   cmd_type          cmd;
   status_type       stat;
   logic [SizeW-1:0] map_size_ff;
   logic             cfg_we;

   // Size register write: completes in the access phase
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CsrMapSizeIdx);
   assign csr_prdata = (csr_paddr[2] == CsrMapSizeIdx) ? CsrDataW'(map_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff <= MapSizeReset;
      end else if (cfg_we) begin
         map_size_ff <= csr_pwdata[SizeW-1:0];
      end
   end

   // Sequencer: accept, read neighbors, write back, then one pass per vertex
   hng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Row store, position counters, normalizer and output word register
   hng_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_height        (req_ch.height),
      .cfg_we            (cfg_we),
      .map_size          (map_size_ff),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_column        (rsp_ch.column),
      .rsp_row           (rsp_ch.row),
      .rsp_vertex_height (rsp_ch.vertex_height),
      .rsp_normal_x      (rsp_ch.normal_x),
      .rsp_normal_y      (rsp_ch.normal_y),
      .rsp_normal_z      (rsp_ch.normal_z),
      .rsp_last_of_run   (rsp_ch.last_of_run),
      .rsp_map_done      (rsp_ch.map_done)
   );

endmodule

// ===== rtl/core/hng_ctrl.sv =====
module hng_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hng_pkg::status_type stat,
   output hng_pkg::cmd_type    cmd
);
   import hng_pkg::*;

   state_type       state_ff, state_in;
   logic [BitW-1:0] cnt_ff, cnt_in;
   vert_type        vsel_ff, vsel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vsel_ff  <= V_ABOVE;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vsel_ff  <= vsel_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      vsel_in    = vsel_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.rd_sel = rd_sel_type'(cnt_ff[2:0]);
      cmd.vsel   = vsel_ff;
      cmd.bitpos = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               cnt_in      = '0;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            if (cnt_ff == BitW'(NumSlots - 1)) begin
               state_in = S_WRITE;
            end else begin
               cnt_in = cnt_ff + BitW'(1);
            end
         end
         S_WRITE: begin
            cmd.wr_en = 1'b1;
            vsel_in   = V_ABOVE;
            state_in  = stat.first_row ? S_IDLE : S_VERT;
         end
         S_VERT: begin
            cmd.vload = 1'b1;
            state_in  = S_SQ;
         end
         S_SQ: begin
            cmd.sq_en = 1'b1;
            state_in  = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = BitW'(LastBit);
            state_in  = S_ITER;
         end
         S_ITER: begin
            cmd.iter = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_PACK;
            end else begin
               cnt_in = cnt_ff - BitW'(1);
            end
         end
         S_PACK: begin
            cmd.out_load = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (stat.rsp_fire) begin
               state_in = S_IDLE;
               case (vsel_ff)
                  V_ABOVE: begin
                     if (stat.has_left) begin
                        vsel_in  = V_LEFT;
                        state_in = S_VERT;
                     end
                  end
                  V_LEFT: begin
                     if (stat.has_corner) begin
                        vsel_in  = V_CORNER;
                        state_in = S_VERT;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/hng_dp.sv =====
module hng_dp (
   input  logic                clock,
   input  logic                reset,
   input  hng_pkg::cmd_type    cmd,
   output hng_pkg::status_type stat,
   input  logic [15:0]         req_height,
   input  logic                cfg_we,
   input  logic [10:0]         map_size,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [9:0]          rsp_column,
   output logic [9:0]          rsp_row,
   output logic [15:0]         rsp_vertex_height,
   output logic [15:0]         rsp_normal_x,
   output logic [14:0]         rsp_normal_y,
   output logic [15:0]         rsp_normal_z,
   output logic                rsp_last_of_run,
   output logic                rsp_map_done
);
   import hng_pkg::*;

   logic [SizeW-1:0]   n_eff, n_last, x_ext, z_ext, x_next, z_next;
   logic [ColW-1:0]    col_ff, row_ff, x_ff, z_ff;
   logic [HeightW-1:0] h_ff;
   logic               bank, last_row, x_gt0, x_ge2, x_lt_last, z_ge2;

   logic [HeightW-1:0] mem [2*MaxSize];
   logic [HeightW-1:0] slot_ff [NumSlots];
   logic [MemAw-1:0]   rd_addr;

   logic [ColW-1:0]    v_col, v_row, vcol_ff, vrow_ff;
   logic [HeightW-1:0] v_own, v_l, v_r, v_d, v_u, vh_ff;
   logic               v_done, v_last, vdone_ff, vlast_ff;
   logic signed [DiffW-1:0] dx_ff, dz_ff;
   logic [SqW-1:0]     dx2_ff, dz2_ff;
   logic [LenW-1:0]    len2;

   logic signed [AccW-1:0] len_ff, len_new;
   logic signed [AccW-1:0] p_ff [NumComp];
   logic signed [AccW-1:0] q_ff [NumComp];
   logic signed [AccW-1:0] r_ff [NumComp];
   logic signed [AccW-1:0] cand [NumComp];
   logic                   take [NumComp];
   logic [LoW-1:0]         lo_ff [NumComp];
   logic                   negx_ff, negz_ff;
   logic [4:0]             sh_q, sh_l, sh_v;
   logic [15:0]            nx_mag, nz_mag;
   logic                   rsp_valid_ff;

   // Clamp the size register into the supported range
   always_comb begin
      if (map_size < SizeW'(2)) begin
         n_eff = SizeW'(2);
      end else if (map_size > SizeW'(MaxSize)) begin
         n_eff = SizeW'(MaxSize);
      end else begin
         n_eff = map_size;
      end
   end

   assign n_last    = n_eff - SizeW'(1);
   assign x_ext     = {1'b0, x_ff};
   assign z_ext     = {1'b0, z_ff};
   assign x_next    = x_ext + SizeW'(1);
   assign z_next    = z_ext + SizeW'(1);
   assign bank      = z_ff[0];
   assign last_row  = (z_ext == n_last);
   assign x_gt0     = (x_ff != '0);
   assign x_ge2     = (x_ext >= SizeW'(2));
   assign x_lt_last = (x_ext < n_last);
   assign z_ge2     = (z_ext >= SizeW'(2));

   assign stat = '{
      first_row:  (z_ff == '0),
      has_left:   last_row && x_gt0,
      has_corner: last_row && (x_ext == n_last),
      rsp_fire:   rsp_valid_ff && rsp_ready
   };

   // Sample position; a size write restarts the map
   always_ff @(posedge clock) begin
      if (reset || cfg_we) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.wr_en) begin
         if (x_next >= n_eff) begin
            col_ff <= '0;
            row_ff <= (z_next >= n_eff) ? '0 : z_next[ColW-1:0];
         end else begin
            col_ff <= x_next[ColW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         h_ff <= req_height;
         if ({1'b0, col_ff} >= n_eff || {1'b0, row_ff} >= n_eff) begin
            x_ff <= '0;
            z_ff <= '0;
         end else begin
            x_ff <= col_ff;
            z_ff <= row_ff;
         end
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_UP_C:  rd_addr = {~bank, x_ff};
         RD_UP_L:  rd_addr = {~bank, x_ff - ColW'(1)};
         RD_UP_R:  rd_addr = {~bank, x_ff + ColW'(1)};
         RD_DN_C:  rd_addr = {bank, x_ff};
         RD_DN_L:  rd_addr = {bank, x_ff - ColW'(1)};
         RD_DN_LL: rd_addr = {bank, x_ff - ColW'(2)};
         default:  rd_addr = {~bank, x_ff};
      endcase
   end

   // Two row banks picked by row parity
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[{bank, x_ff}] <= h_ff;
      end
      if (cmd.rd_en) begin
         slot_ff[cmd.rd_sel] <= mem[rd_addr];
      end
   end

   // Neighbors of the selected vertex; outside the map reads as zero
   always_comb begin
      v_col  = x_ff;
      v_row  = z_ff;
      v_own  = h_ff;
      v_l    = '0;
      v_r    = '0;
      v_d    = '0;
      v_u    = '0;
      v_done = 1'b0;
      v_last = 1'b1;
      case (cmd.vsel)
         V_ABOVE: begin
            v_row  = z_ff - ColW'(1);
            v_own  = slot_ff[RD_UP_C];
            v_l    = x_gt0 ? slot_ff[RD_UP_L] : '0;
            v_r    = x_lt_last ? slot_ff[RD_UP_R] : '0;
            v_d    = z_ge2 ? slot_ff[RD_DN_C] : '0;
            v_u    = h_ff;
            v_last = !stat.has_left && !stat.has_corner;
         end
         V_LEFT: begin
            v_col  = x_ff - ColW'(1);
            v_own  = slot_ff[RD_DN_L];
            v_l    = x_ge2 ? slot_ff[RD_DN_LL] : '0;
            v_r    = h_ff;
            v_d    = slot_ff[RD_UP_L];
            v_last = !stat.has_corner;
         end
         V_CORNER: begin
            v_l    = slot_ff[RD_DN_L];
            v_d    = slot_ff[RD_UP_C];
            v_done = 1'b1;
         end
         default: v_last = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.vload) begin
         vcol_ff  <= v_col;
         vrow_ff  <= v_row;
         vh_ff    <= v_own;
         vdone_ff <= v_done;
         vlast_ff <= v_last;
         dx_ff    <= $signed({v_l[HeightW-1], v_l}) - $signed({v_r[HeightW-1], v_r});
         dz_ff    <= $signed({v_d[HeightW-1], v_d}) - $signed({v_u[HeightW-1], v_u});
      end
      if (cmd.sq_en) begin
         dx2_ff <= SqW'(dx_ff * dx_ff);
         dz2_ff <= SqW'(dz_ff * dz_ff);
      end
   end

   // Round(|c| * 2^14 / sqrt(len2)): grow lo bit by bit while
   // (2*lo - 1)^2 * len2 <= 4 * c^2 * 2^28, with P = (2lo-1)^2*len2 and
   // Q = (2lo-1)*len2 updated by shifts and adds.
   assign len2    = LenW'(dx2_ff) + LenW'(dz2_ff) + LenW'(YSquare);
   assign len_new = $signed(AccW'(len2));
   assign sh_q    = 5'(cmd.bitpos) + 5'd2;
   assign sh_l    = 5'({cmd.bitpos, 1'b0}) + 5'd2;
   assign sh_v    = 5'(cmd.bitpos) + 5'd1;

   always_comb begin
      for (int i = 0; i < NumComp; i++) begin
         cand[i] = p_ff[i] + (q_ff[i] <<< sh_q) + (len_ff <<< sh_l);
         take[i] = (cand[i] <= r_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         len_ff  <= len_new;
         negx_ff <= dx_ff[DiffW-1];
         negz_ff <= dz_ff[DiffW-1];
         r_ff[0] <= $signed(AccW'(dx2_ff)) <<< RhsShift;
         r_ff[1] <= $signed(AccW'(YSquare)) <<< RhsShift;
         r_ff[2] <= $signed(AccW'(dz2_ff)) <<< RhsShift;
         for (int i = 0; i < NumComp; i++) begin
            p_ff[i]  <= len_new;
            q_ff[i]  <= -len_new;
            lo_ff[i] <= '0;
         end
      end else if (cmd.iter) begin
         for (int i = 0; i < NumComp; i++) begin
            if (take[i]) begin
               p_ff[i]  <= cand[i];
               q_ff[i]  <= q_ff[i] + (len_ff <<< sh_v);
               lo_ff[i] <= lo_ff[i] | (LoW'(1) << cmd.bitpos);
            end
         end
      end
   end

   assign nx_mag = {1'b0, lo_ff[0]};
   assign nz_mag = {1'b0, lo_ff[2]};

   // Output word register, held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_column        <= vcol_ff;
         rsp_row           <= vrow_ff;
         rsp_vertex_height <= vh_ff;
         rsp_normal_x      <= negx_ff ? (~nx_mag + 16'd1) : nx_mag;
         rsp_normal_y      <= lo_ff[1];
         rsp_normal_z      <= negz_ff ? (~nz_mag + 16'd1) : nz_mag;
         rsp_last_of_run   <= vlast_ff;
         rsp_map_done      <= vdone_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/hng_checker.sv =====
module hng_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last_of_run,
   input logic rsp_map_done
);

   // Hold a word until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before taken");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result word waits");

   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result word right after accept");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_map_done |-> rsp_last_of_run)
      else $error("map_done without last_of_run");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid out of reset");

endmodule

bind heightmap_normal_generator_core hng_checker u_hng_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_last_of_run (rsp_ch.last_of_run),
   .rsp_map_done    (rsp_ch.map_done)
);
